[src/rhhb_pkg.sv]
// ---------------------------------------------------------------------------
// rhhb_pkg
// Shared widths, register codes, pipeline types and the divide step used by
// the RGB to HSV hue band classifier.
// ---------------------------------------------------------------------------
package rhhb_pkg;

   localparam int COORD_W   = 16;
   localparam int COLOR_W   = 8;
   localparam int HUE_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // hue numerator: 960 * t, t < 2048
   localparam int TERM_W    = 11;
   localparam int NUM_HUE_W = 21;
   localparam int NUM_SAT_W = 16;

   // pipeline shape
   localparam int NSTAGE     = 8;
   localparam int DIV_FIRST  = 3;
   localparam int DIV_STAGES = 4;
   localparam int MAX_STEPS  = 4;
   localparam int HUE_STEPS [DIV_STAGES] = '{4, 3, 3, 3};
   localparam int SAT_STEPS [DIV_STAGES] = '{2, 2, 2, 2};

   // register reset values
   localparam logic signed [COORD_W-1:0] DEPTH_LIMIT_RST = 16'sd2000;
   localparam logic [HUE_W-1:0]          HUE_LOW_RST     = 13'd480;
   localparam logic [HUE_W-1:0]          HUE_HIGH_RST    = 13'd2880;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_LIMIT = 2'd0,
      CSR_HUE_LOW     = 2'd1,
      CSR_HUE_HIGH    = 2'd2
   } csr_index_type;

   // fields that ride along the whole pipe
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [COLOR_W-1:0]        mx;
      logic                      kept;
      logic                      gray;
      logic                      black;
   } side_type;

   // color data needed only up to the hue term
   typedef struct packed {
      logic [COLOR_W-1:0] r;
      logic [COLOR_W-1:0] g;
      logic [COLOR_W-1:0] b;
      logic [COLOR_W-1:0] mn;
      logic               sel_r;
      logic               sel_g;
   } color_type;

   // One restoring divide step: returns {quotient bit, new remainder}.
   // The remainder entering is below the divisor.
   function automatic logic [COLOR_W:0] div_bit(input logic [COLOR_W-1:0] rem,
                                                input logic               nb,
                                                input logic [COLOR_W-1:0] dv);
      logic [COLOR_W:0] trial;
      logic [COLOR_W:0] diff;
      trial = {rem, nb};
      diff  = trial - {1'b0, dv};
      if (trial >= {1'b0, dv}) begin
         return {1'b1, diff[COLOR_W-1:0]};
      end
      return {1'b0, trial[COLOR_W-1:0]};
   endfunction

endpackage

[src/rhhb_divider.sv]
// ---------------------------------------------------------------------------
// rhhb_divider
// Pipelined restoring dividers for hue (13 quotient bits) and saturation
// (8 quotient bits), a few steps per stage.
// ---------------------------------------------------------------------------
module rhhb_divider import rhhb_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] load,
   input  logic [NUM_HUE_W-1:0]  num_hue,
   input  logic [NUM_SAT_W-1:0]  num_sat,
   input  logic [COLOR_W-1:0]    div_hue,
   input  logic [COLOR_W-1:0]    div_sat,
   output logic [HUE_W-1:0]      quo_hue,
   output logic [COLOR_W-1:0]    quo_sat
);

   // accumulator = {remainder, numerator bits left / quotient bits so far}
   logic [NUM_HUE_W-1:0] acc_h_ff [DIV_STAGES];
   logic [NUM_HUE_W-1:0] acc_h_in [DIV_STAGES];
   logic [NUM_SAT_W-1:0] acc_s_ff [DIV_STAGES];
   logic [NUM_SAT_W-1:0] acc_s_in [DIV_STAGES];
   logic [COLOR_W-1:0]   dh_ff    [DIV_STAGES-1];
   logic [COLOR_W-1:0]   ds_ff    [DIV_STAGES-1];

   logic [NUM_HUE_W-1:0] src_h    [DIV_STAGES];
   logic [NUM_SAT_W-1:0] src_s    [DIV_STAGES];
   logic [COLOR_W-1:0]   src_dh   [DIV_STAGES];
   logic [COLOR_W-1:0]   src_ds   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign src_h[k]  = num_hue;
         assign src_s[k]  = num_sat;
         assign src_dh[k] = div_hue;
         assign src_ds[k] = div_sat;
      end else begin : g_next
         assign src_h[k]  = acc_h_ff[k-1];
         assign src_s[k]  = acc_s_ff[k-1];
         assign src_dh[k] = dh_ff[k-1];
         assign src_ds[k] = ds_ff[k-1];
      end

      always_comb begin
         logic [NUM_HUE_W-1:0] h;
         logic [NUM_SAT_W-1:0] s;
         logic [COLOR_W:0]     st;
         h  = src_h[k];
         s  = src_s[k];
         st = '0;
         for (int j = 0; j < MAX_STEPS; j++) begin
            if (j < HUE_STEPS[k]) begin
               st = div_bit(h[NUM_HUE_W-1 -: COLOR_W], h[HUE_W-1], src_dh[k]);
               h  = {st[COLOR_W-1:0], h[HUE_W-2:0], st[COLOR_W]};
            end
            if (j < SAT_STEPS[k]) begin
               st = div_bit(s[NUM_SAT_W-1 -: COLOR_W], s[COLOR_W-1], src_ds[k]);
               s  = {st[COLOR_W-1:0], s[COLOR_W-2:0], st[COLOR_W]};
            end
         end
         acc_h_in[k] = h;
         acc_s_in[k] = s;
      end

      always_ff @(posedge clock) begin
         if (load[k]) begin
            acc_h_ff[k] <= acc_h_in[k];
            acc_s_ff[k] <= acc_s_in[k];
         end
      end

      if (k < DIV_STAGES-1) begin : g_keep
         always_ff @(posedge clock) begin
            if (load[k]) begin
               dh_ff[k] <= src_dh[k];
               ds_ff[k] <= src_ds[k];
            end
         end
      end
   end

   assign quo_hue = acc_h_ff[DIV_STAGES-1][HUE_W-1:0];
   assign quo_sat = acc_s_ff[DIV_STAGES-1][COLOR_W-1:0];

endmodule

[src/rgb_to_hsv_hue_band_classifier.sv]
// ---------------------------------------------------------------------------
// rgb_to_hsv_hue_band_classifier
// Converts the color of one 3-D point to fixed-point HSV, flags it kept by
// depth and in-region by a hue band.
// ---------------------------------------------------------------------------
// Path: max/min and depth test, hue term, numerators, dividers, then the rsp_* registers.
// Throughput: one item per cycle while rsp_stall is low; the two dividers
//   are pipelined over four stages (hue 4+3+3+3 steps, saturation 2 steps a stage).
// Stalls: a stage moves when the one after it is empty or moving; bubbles close up.
// Reset: synchronous, active high; clears all valid bits and loads the
//   register defaults (depth limit 2000, band 480..2880). No clearing pass.
// ---------------------------------------------------------------------------
module rgb_to_hsv_hue_band_classifier import rhhb_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [COORD_W-1:0]  req_pos_x,
   input  logic signed [COORD_W-1:0]  req_pos_y,
   input  logic signed [COORD_W-1:0]  req_pos_z,
   input  logic [COLOR_W-1:0]         req_red,
   input  logic [COLOR_W-1:0]         req_green,
   input  logic [COLOR_W-1:0]         req_blue,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [COORD_W-1:0]  rsp_out_x,
   output logic signed [COORD_W-1:0]  rsp_out_y,
   output logic signed [COORD_W-1:0]  rsp_out_z,
   output logic [HUE_W-1:0]           rsp_hue,
   output logic [COLOR_W-1:0]         rsp_saturation,
   output logic [COLOR_W-1:0]         rsp_brightness,
   output logic                       rsp_kept,
   output logic                       rsp_in_region,

   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DAT_W-1:0]       csr_data
);

   // ---------------- configuration registers ----------------
   logic signed [COORD_W-1:0] depth_limit_ff;
   logic [HUE_W-1:0]          hue_low_ff;
   logic [HUE_W-1:0]          hue_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_limit_ff <= DEPTH_LIMIT_RST;
         hue_low_ff     <= HUE_LOW_RST;
         hue_high_ff    <= HUE_HIGH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEPTH_LIMIT: depth_limit_ff <= $signed(csr_data);
            CSR_HUE_LOW:     hue_low_ff     <= csr_data[HUE_W-1:0];
            CSR_HUE_HIGH:    hue_high_ff    <= csr_data[HUE_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // free[k]: stage k can take new contents this cycle.
   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] free;

   always_comb begin
      free[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
      for (int k = NSTAGE-2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      valid_in[0] = free[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTAGE; k++) begin
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !free[0];
   assign rsp_valid = valid_ff[NSTAGE-1];

   // ---------------- stage 0: max / min, depth test ----------------
   side_type  side_ff [NSTAGE-1];
   side_type  side_in0;
   color_type col_ff;
   color_type col_in;

   always_comb begin
      logic [COLOR_W-1:0] mx;
      logic [COLOR_W-1:0] mn;
      mx = req_red;
      mn = req_red;
      if (req_green > mx) mx = req_green;
      if (req_blue  > mx) mx = req_blue;
      if (req_green < mn) mn = req_green;
      if (req_blue  < mn) mn = req_blue;

      side_in0.x     = req_pos_x;
      side_in0.y     = req_pos_y;
      side_in0.z     = req_pos_z;
      side_in0.mx    = mx;
      side_in0.kept  = req_pos_z < depth_limit_ff;
      side_in0.gray  = mx == mn;       // covers black too
      side_in0.black = mx == '0;

      col_in.r     = req_red;
      col_in.g     = req_green;
      col_in.b     = req_blue;
      col_in.mn    = mn;
      col_in.sel_r = mx == req_red;    // ties go to red, then green
      col_in.sel_g = req_green >= req_blue;
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         side_ff[0] <= side_in0;
         col_ff     <= col_in;
      end
   end

   // ---------------- stage 1: d and sector hue term ----------------
   // hue = 960 * t / d, with t folding in the sector offset:
   //   red max:   g - b, or 6d - (b - g) when negative (wrap)
   //   green max: 2d + b - r
   //   blue max:  4d + r - g
   logic [COLOR_W-1:0] d1_ff;
   logic [COLOR_W-1:0] d1_in;
   logic [TERM_W-1:0]  t1_ff;
   logic [TERM_W-1:0]  t1_in;

   always_comb begin
      logic [TERM_W:0] r12;
      logic [TERM_W:0] g12;
      logic [TERM_W:0] b12;
      logic [TERM_W:0] d12;
      logic [TERM_W:0] t12;
      r12   = {{(TERM_W+1-COLOR_W){1'b0}}, col_ff.r};
      g12   = {{(TERM_W+1-COLOR_W){1'b0}}, col_ff.g};
      b12   = {{(TERM_W+1-COLOR_W){1'b0}}, col_ff.b};
      d1_in = side_ff[0].mx - col_ff.mn;
      d12   = {{(TERM_W+1-COLOR_W){1'b0}}, d1_in};
      if (col_ff.sel_r) begin
         if (col_ff.g >= col_ff.b) begin
            t12 = g12 - b12;
         end else begin
            t12 = (d12 << 2) + (d12 << 1) - (b12 - g12);
         end
      end else if (col_ff.sel_g) begin
         t12 = (d12 << 1) + b12 - r12;
      end else begin
         t12 = (d12 << 2) + r12 - g12;
      end
      t1_in = t12[TERM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (free[1]) begin
         side_ff[1] <= side_ff[0];
         d1_ff      <= d1_in;
         t1_ff      <= t1_in;
      end
   end

   // ---------------- stage 2: numerators ----------------
   // 960*t = 1024t - 64t, 255*d = 256d - d
   logic [NUM_HUE_W-1:0] num_hue_ff;
   logic [NUM_HUE_W-1:0] num_hue_in;
   logic [NUM_SAT_W-1:0] num_sat_ff;
   logic [NUM_SAT_W-1:0] num_sat_in;
   logic [COLOR_W-1:0]   d2_ff;

   assign num_hue_in = {t1_ff, 10'b0} - {4'b0, t1_ff, 6'b0};
   assign num_sat_in = {d1_ff, 8'b0} - {8'b0, d1_ff};

   always_ff @(posedge clock) begin
      if (free[2]) begin
         side_ff[2] <= side_ff[1];
         num_hue_ff <= num_hue_in;
         num_sat_ff <= num_sat_in;
         d2_ff      <= d1_ff;
      end
   end

   // ---------------- stages 3..6: dividers ----------------
   logic [HUE_W-1:0]   quo_hue;
   logic [COLOR_W-1:0] quo_sat;

   rhhb_divider u_div (
      .clock   (clock),
      .load    (free[DIV_FIRST +: DIV_STAGES]),
      .num_hue (num_hue_ff),
      .num_sat (num_sat_ff),
      .div_hue (d2_ff),
      .div_sat (side_ff[2].mx),
      .quo_hue (quo_hue),
      .quo_sat (quo_sat)
   );

   for (genvar k = DIV_FIRST; k < NSTAGE-1; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (free[k]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // ---------------- stage 7: specials, band test, output ----------------
   // Divider results are meaningless for a zero divisor; gray and black
   // points are forced to zero here.
   logic [HUE_W-1:0]   hue_in;
   logic [COLOR_W-1:0] sat_in;
   logic               region_in;
   side_type           last;

   assign last      = side_ff[NSTAGE-2];
   assign hue_in    = last.gray  ? '0 : quo_hue;
   assign sat_in    = last.black ? '0 : quo_sat;
   assign region_in = last.kept && (hue_in >= hue_low_ff) && (hue_in <= hue_high_ff);

   always_ff @(posedge clock) begin
      if (free[NSTAGE-1]) begin
         rsp_out_x      <= last.x;
         rsp_out_y      <= last.y;
         rsp_out_z      <= last.z;
         rsp_hue        <= hue_in;
         rsp_saturation <= sat_in;
         rsp_brightness <= last.mx;
         rsp_kept       <= last.kept;
         rsp_in_region  <= region_in;
      end
   end

endmodule

[src/rhhb_checker.sv]
// ---------------------------------------------------------------------------
// rhhb_checker
// Port-level checks on the result channel of the hue band classifier.
// ---------------------------------------------------------------------------
module rhhb_checker import rhhb_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [HUE_W-1:0]          rsp_hue,
   input logic [COLOR_W-1:0]        rsp_saturation,
   input logic [COLOR_W-1:0]        rsp_brightness,
   input logic                      rsp_kept,
   input logic                      rsp_in_region
);

   // a stalled result stays and holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_in_region))
      else $error("result changed while stalled");

   // hue wraps into one turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue <= 13'd5759)
      else $error("hue out of range");

   // only kept points can be in the band
   a_region_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_region |-> rsp_kept)
      else $error("in_region without kept");

   // zero saturation means gray, which has hue 0; black has zero saturation
   a_gray: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_saturation == '0 || rsp_brightness == '0)
         |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("gray or black point with color");

endmodule

bind rgb_to_hsv_hue_band_classifier rhhb_checker u_rhhb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hue        (rsp_hue),
   .rsp_saturation (rsp_saturation),
   .rsp_brightness (rsp_brightness),
   .rsp_kept       (rsp_kept),
   .rsp_in_region  (rsp_in_region)
);

[sim/rgb_to_hsv_hue_band_classifier_tb.sv]
// ---------------------------------------------------------------------------
// rgb_to_hsv_hue_band_classifier_tb
// Self-checking bench for the point color classifier. A queue of points is
// streamed through the block under random sender gaps and receiver stalls.
// Every accepted point is scored in the bench (HSV, depth keep, hue band)
// and each result is checked field by field, in order, against that score.
// The band and depth registers are rewritten between phases while idle.
// ---------------------------------------------------------------------------
module rgb_to_hsv_hue_band_classifier_tb;
   import rhhb_pkg::*;

   // drain padding after the last result, beyond the block's pipeline
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 2000;
   // one long receiver hold-off so the pipe backs up into req_stall
   localparam int STALL_BURST_AT  = 300;
   localparam int STALL_BURST_LEN = 150;
   localparam int HUE_TOP         = 5759;

   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [COLOR_W-1:0]        red;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        blue;
   } color_point_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [HUE_W-1:0]          hue;
      logic [COLOR_W-1:0]        sat;
      logic [COLOR_W-1:0]        val;
      logic                      kept;
      logic                      in_band;
   } hsv_point_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [COORD_W-1:0] req_pos_z = '0;
   logic [COLOR_W-1:0]        req_red   = '0;
   logic [COLOR_W-1:0]        req_green = '0;
   logic [COLOR_W-1:0]        req_blue  = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [COORD_W-1:0] rsp_out_x;
   logic signed [COORD_W-1:0] rsp_out_y;
   logic signed [COORD_W-1:0] rsp_out_z;
   logic [HUE_W-1:0]          rsp_hue;
   logic [COLOR_W-1:0]        rsp_saturation;
   logic [COLOR_W-1:0]        rsp_brightness;
   logic                      rsp_kept;
   logic                      rsp_in_region;

   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DAT_W-1:0]      csr_data  = '0;

   // bench copy of the three registers
   logic signed [COORD_W-1:0] cfg_depth_limit;
   logic [HUE_W-1:0]          cfg_hue_low;
   logic [HUE_W-1:0]          cfg_hue_high;

   color_point_type pending_points[$];
   hsv_point_type   expected_hsv[$];

   // handshake flags captured at the rising edge, read at the falling edge
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;

   int  mismatch_count = 0;
   int  results_taken  = 0;
   int  quiet_cycles   = 0;
   int  tx_wait        = 0;
   int  rx_wait        = 0;
   bit  tx_eager       = 1'b0;
   bit  rx_eager       = 1'b0;
   bit  burst_done     = 1'b0;

   rgb_to_hsv_hue_band_classifier u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness),
      .rsp_kept       (rsp_kept),
      .rsp_in_region  (rsp_in_region),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Scoring of one point. Hue is six sectors of 960 (1/16 degree), the
   // sector picked by the largest byte with ties going red, then green.
   // Each sector offset is folded into the numerator so the divide is always
   // of a non-negative value and plain integer division truncates correctly.
   // -------------------------------------------------------------------------
   function automatic hsv_point_type classify_point(input color_point_type p);
      int            r, g, b, top, bottom, span, numer;
      hsv_point_type res;
      r = p.red;
      g = p.green;
      b = p.blue;
      top    = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
      bottom = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
      span   = top - bottom;
      res.x   = p.x;
      res.y   = p.y;
      res.z   = p.z;
      res.val = 8'(top);
      res.sat = '0;
      res.hue = '0;
      // black: no saturation; gray: no hue
      if (top != 0) begin
         res.sat = 8'((255 * span) / top);
      end
      if (span != 0) begin
         if (top == r) begin
            // negative red sector wraps up by a full turn
            numer = 960 * (g - b) + ((g < b) ? 5760 * span : 0);
         end else if (top == g) begin
            numer = 1920 * span + 960 * (b - r);
         end else begin
            numer = 3840 * span + 960 * (r - g);
         end
         res.hue = 13'(numer / span);
      end
      res.kept    = ($signed(p.z) < cfg_depth_limit);
      // an inverted band or a lower bound past 5759 simply never matches
      res.in_band = res.kept && (res.hue >= cfg_hue_low) && (res.hue <= cfg_hue_high);
      return res;
   endfunction

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // -------------------------------------------------------------------------
   // Monitor: sample every handshake at the rising edge. Accepted input
   // items are scored with the registers as they stand; results are popped
   // oldest first. The watchdog counts edges where nothing moves at all.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      color_point_type seen;
      hsv_point_type   want;
      req_took <= !reset && req_valid && !req_stall;
      rsp_took <= !reset && rsp_valid && !rsp_stall;
      if (reset) begin
         cfg_depth_limit = 16'sd2000;
         cfg_hue_low     = 13'd480;
         cfg_hue_high    = 13'd2880;
         quiet_cycles    = 0;
      end else begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            quiet_cycles = 0;
            case (csr_index)
               CSR_DEPTH_LIMIT: cfg_depth_limit = csr_data;
               CSR_HUE_LOW:     cfg_hue_low     = csr_data[HUE_W-1:0];
               CSR_HUE_HIGH:    cfg_hue_high    = csr_data[HUE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            seen = {req_pos_x, req_pos_y, req_pos_z, req_red, req_green, req_blue};
            expected_hsv = {expected_hsv, classify_point(seen)};
         end
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            results_taken++;
            if (expected_hsv.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing expected, expected none, actual hue %0d",
                        $time, rsp_hue);
            end else begin
               want = expected_hsv.pop_front();
               check_field("out_x",      want.x,       rsp_out_x);
               check_field("out_y",      want.y,       rsp_out_y);
               check_field("out_z",      want.z,       rsp_out_z);
               check_field("hue",        want.hue,     rsp_hue);
               check_field("saturation", want.sat,     rsp_saturation);
               check_field("brightness", want.val,     rsp_brightness);
               check_field("kept",       want.kept,    rsp_kept);
               check_field("in_region",  want.in_band, rsp_in_region);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("rgb_to_hsv_hue_band_classifier_tb: errors");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver: present the next point once the current one is taken, after a
   // random gap. A stalled point is held as is. Now and then the gap draw
   // switches to zero for a stretch of back-to-back items.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin : drive_points
      color_point_type pt;
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else if (!req_valid || req_took) begin
         if (tx_wait > 0) begin
            req_valid <= 1'b0;
            tx_wait--;
         end else if (pending_points.size() != 0) begin
            pt = pending_points.pop_front();
            req_pos_x <= pt.x;
            req_pos_y <= pt.y;
            req_pos_z <= pt.z;
            req_red   <= pt.red;
            req_green <= pt.green;
            req_blue  <= pt.blue;
            req_valid <= 1'b1;
            if ($urandom_range(0, 31) == 0) tx_eager = !tx_eager;
            tx_wait = tx_eager ? 0 : $urandom_range(0, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: after each result taken, stall for a random count of cycles.
   // Once, after STALL_BURST_AT results, hold off much longer so the pipe
   // fills and backs up while the driver keeps offering.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_took) begin
            if ($urandom_range(0, 31) == 0) rx_eager = !rx_eager;
            rx_wait = rx_eager ? 0 : $urandom_range(0, 10);
            if (!burst_done && results_taken >= STALL_BURST_AT) begin
               rx_wait    = STALL_BURST_LEN;
               burst_done = 1'b1;
            end
         end
         rsp_stall <= (rx_wait != 0);
         if (rx_wait != 0) rx_wait--;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_point(input int x, input int y, input int z,
                            input int r, input int g, input int b);
      color_point_type p;
      p = '{16'(x), 16'(y), 16'(z), 8'(r), 8'(g), 8'(b)};
      pending_points = {pending_points, p};
   endtask

   // Random colors lean on the awkward shapes: gray, black, ties on the
   // largest or smallest byte, near-black. Depth is either anywhere or
   // within a few millimetres of the current limit.
   task automatic add_random(input int count);
      color_point_type p;
      int              zv, hi, lo, v;
      repeat (count) begin
         p.x = 16'($urandom);
         p.y = 16'($urandom);
         if ($urandom_range(0, 1) == 0) begin
            p.z = 16'($urandom);
         end else begin
            zv = $urandom_range(0, 6);
            zv = zv - 3 + cfg_depth_limit;
            if (zv > 32767) zv = 32767;
            if (zv < -32768) zv = -32768;
            p.z = 16'(zv);
         end
         p.red   = 8'($urandom);
         p.green = 8'($urandom);
         p.blue  = 8'($urandom);
         case ($urandom_range(0, 9))
            0: begin
               v = $urandom_range(0, 255);
               p.red   = 8'(v);
               p.green = 8'(v);
               p.blue  = 8'(v);
            end
            1: begin
               p.red   = '0;
               p.green = '0;
               p.blue  = '0;
            end
            2, 3: begin
               hi = $urandom_range(1, 255);
               lo = $urandom_range(0, hi - 1);
               case ($urandom_range(0, 3))
                  0: p = '{p.x, p.y, p.z, 8'(hi), 8'(hi), 8'(lo)};
                  1: p = '{p.x, p.y, p.z, 8'(hi), 8'(lo), 8'(hi)};
                  2: p = '{p.x, p.y, p.z, 8'(lo), 8'(hi), 8'(hi)};
                  default: p = '{p.x, p.y, p.z, 8'(lo), 8'(lo), 8'(hi)};
               endcase
            end
            4: begin
               p.red   = 8'($urandom_range(0, 3));
               p.green = 8'($urandom_range(0, 3));
               p.blue  = 8'($urandom_range(0, 3));
            end
            default: ;
         endcase
         pending_points = {pending_points, p};
      end
   endtask

   // idle means: nothing queued, nothing offered, nothing outstanding
   task automatic settle();
      while (pending_points.size() != 0 || req_valid || expected_hsv.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Sequence of phases; registers change only between them.
   // -------------------------------------------------------------------------
   initial begin : run_phases
      int lo, hi, tmp;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset band 480..2880, depth limit 2000
      add_point(0, 0, 0, 0, 0, 0);                 // black
      add_point(-32768, 32767, 1999, 128, 128, 128); // gray, kept, hue 0 out
      add_point(32767, -32768, 2000, 255, 255, 255); // white, depth on limit
      add_point(0, 0, -32768, 1, 1, 1);
      add_point(1, -1, 32767, 255, 0, 0);          // pure red, far
      add_point(100, 200, 0, 255, 0, 1);           // red wraps to 5756
      add_point(-100, -200, 0, 255, 0, 255);       // red/blue tie goes red
      add_point(21845, -21846, 0, 255, 255, 0);    // red/green tie
      add_point(0, 0, 10, 0, 255, 0);
      add_point(0, 0, 10, 0, 255, 255);            // upper band edge 2880
      add_point(0, 0, 10, 0, 254, 255);            // just above the band
      add_point(0, 0, 10, 0, 0, 255);
      add_point(0, 0, 10, 254, 127, 0);            // lower band edge 480
      add_point(0, 0, 10, 255, 127, 0);            // just below the band
      add_point(0, 0, 10, 1, 0, 0);                // full saturation, dim
      add_point(0, 0, 10, 255, 254, 254);          // saturation 1
      add_point(0, 0, 10, 0, 0, 1);
      add_point(-1, -1, 1999, 37, 200, 90);
      add_point(12345, -12345, -1, 200, 90, 37);
      add_point(-21846, 21845, 1, 90, 37, 200);
      settle();

      // whole hue circle in band, depth limit at zero
      write_reg(CSR_DEPTH_LIMIT, 16'h0000);
      write_reg(CSR_HUE_LOW, 16'd0);
      write_reg(CSR_HUE_HIGH, 16'(HUE_TOP));
      add_random(150);
      settle();

      // nothing can be kept; band is the single hue 0
      write_reg(CSR_DEPTH_LIMIT, 16'h8000);
      write_reg(CSR_HUE_HIGH, 16'd0);
      add_point(0, 0, -32768, 50, 50, 50);
      add_random(60);
      settle();

      // everything but the deepest kept; band is 5759 only, junk above bit 12
      write_reg(CSR_DEPTH_LIMIT, 16'h7FFF);
      write_reg(CSR_HUE_LOW, {3'b111, 13'(HUE_TOP)});
      write_reg(CSR_HUE_HIGH, {3'b101, 13'(HUE_TOP)});
      add_point(0, 0, 32767, 255, 0, 0);
      add_point(0, 0, 32766, 255, 0, 0);
      add_random(60);
      settle();

      // inverted band: always empty
      write_reg(CSR_DEPTH_LIMIT, 16'd2000);
      write_reg(CSR_HUE_LOW, 16'd3000);
      write_reg(CSR_HUE_HIGH, 16'd1000);
      add_random(60);
      settle();

      // bounds past the largest hue, then a write to the spare index
      write_reg(CSR_HUE_LOW, 16'd5760);
      write_reg(CSR_HUE_HIGH, 16'h1FFF);
      write_reg(CSR_UNUSED, 16'hFFFF);
      add_random(60);
      settle();

      // random settings, mostly ordered bands
      repeat (5) begin
         lo = $urandom_range(0, HUE_TOP);
         hi = $urandom_range(0, HUE_TOP);
         if (lo > hi && $urandom_range(0, 3) != 0) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
         end
         write_reg(CSR_DEPTH_LIMIT, 16'($urandom));
         write_reg(CSR_HUE_LOW, {3'($urandom), 13'(lo)});
         write_reg(CSR_HUE_HIGH, {3'($urandom), 13'(hi)});
         add_random(90);
         settle();
      end

      if (mismatch_count == 0) begin
         $display("rgb_to_hsv_hue_band_classifier_tb: clean");
      end else begin
         $display("rgb_to_hsv_hue_band_classifier_tb: errors");
      end
      $finish;
   end

endmodule

[filelist.f]
src/rhhb_pkg.sv
src/rhhb_divider.sv
src/rgb_to_hsv_hue_band_classifier.sv
src/rhhb_checker.sv
sim/rgb_to_hsv_hue_band_classifier_tb.sv
